// ----- src/dct_pkg.sv -----
// ----------------------------------------------------------------------------
// Dirty chunk tracker package
// Shared widths, command and status codes, and the queued request type.
// ----------------------------------------------------------------------------
`default_nettype none

package dct_pkg;

   localparam int IDX_W   = 12;   // chunk index width
   localparam int LIM_W   = 7;    // read limit width
   localparam int CNT_W   = 7;    // list count width
   localparam int STAT_W  = 3;    // status width
   localparam int CFG_W   = 13;   // chunks_in_use register width
   localparam int ROW_W   = 64;   // mark bits per memory row
   localparam int ROW_BW  = 6;    // bit position within a row
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;

   localparam logic [CFG_W-1:0] CHUNKS_RESET = 13'd4096;

   // Command codes on req_cmd.
   localparam logic [1:0] CMD_MARK  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_ADDED   = 3'd0;
   localparam logic [STAT_W-1:0] ST_ALREADY = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STAT_W-1:0] ST_REJECT  = 3'd3;
   localparam logic [STAT_W-1:0] ST_DONE    = 3'd4;

   // Operation after classification by the front end.
   typedef enum logic [1:0] {
      OP_MARK   = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_REJECT = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   chunk_index;
      logic [LIM_W-1:0]   read_limit;   // already clamped to the list depth
   } entry_type;

endpackage

`default_nettype wire

// ----- src/dct_front.sv -----
// ----------------------------------------------------------------------------
// Dirty chunk tracker front end
// Classifies an incoming request: range check and read limit clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module dct_front #(
   parameter int MAX_CHUNKS = 4096,
   parameter int LIST_DEPTH = 64
) (
   input  wire logic [1:0]                 req_cmd,
   input  wire logic [dct_pkg::IDX_W-1:0]  req_chunk_index,
   input  wire logic [dct_pkg::LIM_W-1:0]  req_read_limit,
   input  wire logic [dct_pkg::CFG_W-1:0]  chunks_in_use,
   output dct_pkg::entry_type              entry
);
   import dct_pkg::*;

   logic [31:0] limit;
   logic        in_range;

   // The usable chunk count saturates at the size of the mark store.
   assign limit    = (32'(chunks_in_use) > 32'(MAX_CHUNKS)) ? 32'(MAX_CHUNKS)
                                                             : 32'(chunks_in_use);
   assign in_range = 32'(req_chunk_index) < limit;

   always_comb begin
      entry.chunk_index = req_chunk_index;
      entry.read_limit  = (req_read_limit > LIM_W'(LIST_DEPTH)) ? LIM_W'(LIST_DEPTH)
                                                                 : req_read_limit;
      unique case (req_cmd)
         CMD_MARK:  entry.op = in_range ? OP_MARK : OP_REJECT;
         CMD_READ:  entry.op = OP_READ;
         CMD_CLEAR: entry.op = OP_CLEAR;
         default:   entry.op = OP_REJECT;
      endcase
   end

endmodule

`default_nettype wire

// ----- src/dct_queue.sv -----
// ----------------------------------------------------------------------------
// Dirty chunk tracker request queue
// Two-entry FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dct_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire dct_pkg::entry_type push_entry,
   input  wire logic        pop,
   output dct_pkg::entry_type head,
   output logic             not_empty,
   output logic             full
);
   import dct_pkg::*;

   entry_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       fill_ff, fill_in;

   assign not_empty = fill_ff != '0;
   assign full      = fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- src/dct_back.sv -----
// ----------------------------------------------------------------------------
// Dirty chunk tracker back end
// Owns the mark store and dirty list and executes queued requests.
// ----------------------------------------------------------------------------
`default_nettype none

module dct_back #(
   parameter int MAX_CHUNKS = 4096,
   parameter int LIST_DEPTH = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_valid,
   input  wire dct_pkg::entry_type          q_head,
   output logic                             q_pop,
   output logic                             init_active,
   output logic                             rsp_strobe,
   output logic [dct_pkg::IDX_W-1:0]        rsp_listed_index,
   output logic                             rsp_index_valid,
   output logic                             rsp_last,
   output logic [dct_pkg::STAT_W-1:0]       rsp_status,
   output logic [dct_pkg::CNT_W-1:0]        rsp_dirty_total,
   output logic                             rsp_rebuild_needed
);
   import dct_pkg::*;

   localparam int NUM_ROWS = (MAX_CHUNKS + ROW_W - 1) / ROW_W;
   localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int LIST_AW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(NUM_ROWS - 1);

   typedef enum logic [4:0] {
      S_INIT  = 5'b00001,
      S_IDLE  = 5'b00010,
      S_MARK  = 5'b00100,
      S_READ  = 5'b01000,
      S_CLEAR = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   entry_type           cur_ff, cur_in;
   logic [ROW_AW-1:0]   row_ff, row_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rebuild_ff, rebuild_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;     // list entry now in the read register
   logic [CNT_W-1:0]    total_ff, total_in; // entries this read returns

   // Mark store: one bit per chunk, ROW_W chunks to a row.
   logic [ROW_W-1:0]    mark_mem [NUM_ROWS];
   logic [ROW_W-1:0]    mark_rdata_ff;
   logic                mark_re, mark_we;
   logic [ROW_AW-1:0]   mark_raddr, mark_waddr;
   logic [ROW_W-1:0]    mark_wdata;

   // Dirty list.
   logic [IDX_W-1:0]    list_mem [LIST_DEPTH];
   logic [IDX_W-1:0]    list_rdata_ff;
   logic                list_re, list_we;
   logic [LIST_AW-1:0]  list_raddr;

   logic                strobe_ff, strobe_in;
   logic [IDX_W-1:0]    index_ff, index_in;
   logic                ivalid_ff, ivalid_in;
   logic                last_ff, last_in;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic [CNT_W-1:0]    dtotal_ff, dtotal_in;
   logic                rneed_ff, rneed_in;

   logic [31:0]         head_ext, cur_ext;
   logic [CNT_W-1:0]    head_total, pos_next, count_next;
   logic                cur_marked;

   assign head_ext   = 32'(q_head.chunk_index);
   assign cur_ext    = 32'(cur_ff.chunk_index);
   assign head_total = (count_ff < q_head.read_limit) ? count_ff : q_head.read_limit;
   assign pos_next   = pos_ff + 1'b1;
   assign count_next = count_ff + 1'b1;
   assign cur_marked = mark_rdata_ff[cur_ff.chunk_index[ROW_BW-1:0]];

   assign init_active = state_ff == S_INIT;

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      row_in     = row_ff;
      count_in   = count_ff;
      rebuild_in = rebuild_ff;
      pos_in     = pos_ff;
      total_in   = total_ff;
      q_pop      = 1'b0;
      mark_re    = 1'b0;
      mark_raddr = head_ext[ROW_AW+ROW_BW-1:ROW_BW];
      mark_we    = 1'b0;
      mark_waddr = row_ff;
      mark_wdata = '0;
      list_re    = 1'b0;
      list_raddr = '0;
      list_we    = 1'b0;
      strobe_in  = 1'b0;
      index_in   = '0;
      ivalid_in  = 1'b0;
      last_in    = 1'b1;
      status_in  = ST_DONE;
      dtotal_in  = count_ff;
      rneed_in   = rebuild_ff;

      unique case (state_ff)
         S_INIT: begin
            mark_we = 1'b1;
            if (row_ff == LAST_ROW) begin
               state_in = S_IDLE;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               unique case (q_head.op)
                  OP_MARK: begin
                     mark_re  = 1'b1;
                     state_in = S_MARK;
                  end
                  OP_READ: begin
                     if (head_total == '0) begin
                        strobe_in = 1'b1;
                     end else begin
                        list_re  = 1'b1;
                        pos_in   = '0;
                        total_in = head_total;
                        state_in = S_READ;
                     end
                  end
                  OP_CLEAR: begin
                     row_in   = '0;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     strobe_in = 1'b1;
                     status_in = ST_REJECT;
                  end
               endcase
            end
         end

         S_MARK: begin
            strobe_in  = 1'b1;
            state_in   = S_IDLE;
            mark_waddr = cur_ext[ROW_AW+ROW_BW-1:ROW_BW];
            mark_wdata = mark_rdata_ff | (ROW_W'(1) << cur_ff.chunk_index[ROW_BW-1:0]);
            if (cur_marked) begin
               status_in = ST_ALREADY;
            end else begin
               mark_we = 1'b1;
               if (count_ff < CNT_W'(LIST_DEPTH)) begin
                  list_we   = 1'b1;
                  count_in  = count_next;
                  dtotal_in = count_next;
                  status_in = ST_ADDED;
               end else begin
                  rebuild_in = 1'b1;
                  rneed_in   = 1'b1;
                  status_in  = ST_FULL;
               end
            end
         end

         S_READ: begin
            strobe_in = 1'b1;
            index_in  = list_rdata_ff;
            ivalid_in = 1'b1;
            last_in   = pos_next == total_ff;
            if (pos_next == total_ff) begin
               state_in = S_IDLE;
            end else begin
               list_re    = 1'b1;
               list_raddr = pos_next[LIST_AW-1:0];
               pos_in     = pos_next;
            end
         end

         S_CLEAR: begin
            mark_we = 1'b1;
            if (row_ff == LAST_ROW) begin
               count_in   = '0;
               rebuild_in = 1'b0;
               strobe_in  = 1'b1;
               dtotal_in  = '0;
               rneed_in   = 1'b0;
               state_in   = S_IDLE;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_INIT;
         row_ff     <= '0;
         count_ff   <= '0;
         rebuild_ff <= 1'b1;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         row_ff     <= row_in;
         count_ff   <= count_in;
         rebuild_ff <= rebuild_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      pos_ff    <= pos_in;
      total_ff  <= total_in;
      index_ff  <= index_in;
      ivalid_ff <= ivalid_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      dtotal_ff <= dtotal_in;
      rneed_ff  <= rneed_in;
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      if (mark_re) begin
         mark_rdata_ff <= mark_mem[mark_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[count_ff[LIST_AW-1:0]] <= cur_ff.chunk_index;
      end
      if (list_re) begin
         list_rdata_ff <= list_mem[list_raddr];
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_listed_index   = index_ff;
   assign rsp_index_valid    = ivalid_ff;
   assign rsp_last           = last_ff;
   assign rsp_status         = status_ff;
   assign rsp_dirty_total    = dtotal_ff;
   assign rsp_rebuild_needed = rneed_ff;

endmodule

`default_nettype wire

// ----- src/dirty_chunk_tracker_top.sv -----
// ----------------------------------------------------------------------------
// Dirty chunk tracker
// Tracks dirty chunks in a mark store and an ordered dirty list.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// It carries a command (mark, read or clear), a chunk index for mark and a
// read limit for read. The front end classifies it and places it in a
// two-entry queue; the back end takes requests from the queue one at a time.
// Results appear on the rsp_ ports for one cycle each, flagged by rsp_strobe.
// The receiver cannot stall, so results are simply taken as they come.
// With the back end idle, a reject or empty read result is registered as
// the back end pops the request from the queue; a mark result or the first
// entry of a read follows once its mark store row or list entry is in the
// read register. A mark writes back its mark store row before the next
// request is taken. A read returns its entries one per cycle. A clear sweeps
// the mark store one row per cycle over MAX_CHUNKS/64 rows (64 at the
// default size), and then gives its single result. After reset the same
// sweep runs with busy held high; the chunk count register resets to 4096,
// the list is empty and the rebuild flag is set. The chunks_in_use register
// is written on the csr_ channel, which is always ready; the user must write
// it only while no request is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module dirty_chunk_tracker_top #(
   parameter int MAX_CHUNKS = 4096,
   parameter int LIST_DEPTH = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_cmd,
   input  wire logic [dct_pkg::IDX_W-1:0]    req_chunk_index,
   input  wire logic [dct_pkg::LIM_W-1:0]    req_read_limit,
   output logic                              rsp_strobe,
   output logic [dct_pkg::IDX_W-1:0]         rsp_listed_index,
   output logic                              rsp_index_valid,
   output logic                              rsp_last,
   output logic [dct_pkg::STAT_W-1:0]        rsp_status,
   output logic [dct_pkg::CNT_W-1:0]         rsp_dirty_total,
   output logic                              rsp_rebuild_needed,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [dct_pkg::CFG_W-1:0]    csr_chunks_in_use
);
   import dct_pkg::*;

   logic [CFG_W-1:0] chunks_ff, chunks_in;
   entry_type        front_entry;
   entry_type        q_head;
   logic             q_valid, q_full, q_pop, q_push;
   logic             init_active;

   // The register port never stalls.
   assign csr_ready = 1'b1;
   assign chunks_in = (csr_valid && csr_ready) ? csr_chunks_in_use : chunks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunks_ff <= CHUNKS_RESET;
      end else begin
         chunks_ff <= chunks_in;
      end
   end

   // New requests are refused while the queue is full or the mark store is
   // still being swept after reset.
   assign busy   = q_full || init_active;
   assign q_push = start && !busy;

   dct_front #(
      .MAX_CHUNKS (MAX_CHUNKS),
      .LIST_DEPTH (LIST_DEPTH)
   ) u_front (
      .req_cmd         (req_cmd),
      .req_chunk_index (req_chunk_index),
      .req_read_limit  (req_read_limit),
      .chunks_in_use   (chunks_ff),
      .entry           (front_entry)
   );

   dct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (front_entry),
      .pop        (q_pop),
      .head       (q_head),
      .not_empty  (q_valid),
      .full       (q_full)
   );

   dct_back #(
      .MAX_CHUNKS (MAX_CHUNKS),
      .LIST_DEPTH (LIST_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .init_active        (init_active),
      .rsp_strobe         (rsp_strobe),
      .rsp_listed_index   (rsp_listed_index),
      .rsp_index_valid    (rsp_index_valid),
      .rsp_last           (rsp_last),
      .rsp_status         (rsp_status),
      .rsp_dirty_total    (rsp_dirty_total),
      .rsp_rebuild_needed (rsp_rebuild_needed)
   );

endmodule

`default_nettype wire

// ----- src/dct_checker.sv -----
// ----------------------------------------------------------------------------
// Dirty chunk tracker checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dct_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         busy,
   input wire logic                         rsp_strobe,
   input wire logic                         rsp_index_valid,
   input wire logic                         rsp_last,
   input wire logic [dct_pkg::STAT_W-1:0]   rsp_status,
   input wire logic [dct_pkg::CNT_W-1:0]    rsp_dirty_total
);
   import dct_pkg::*;

   // A list read streams its entries in consecutive cycles.
   a_read_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("read stream broke before its last entry");

   // Entries come only from reads, which report done.
   a_entry_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_index_valid |-> rsp_status == ST_DONE)
      else $error("list entry with a status other than done");

   // A result without an entry is the only result of its request.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_index_valid |-> rsp_last)
      else $error("entry-less result not marked last");

   // An added chunk leaves the list non-empty.
   a_added_total: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_ADDED |-> rsp_dirty_total != '0)
      else $error("chunk added but list count is zero");

   // The mark store sweep after reset holds off requests.
   a_reset_busy: assert property (@(posedge clock)
      reset |=> busy && !rsp_strobe)
      else $error("not busy or result shown right after reset");

endmodule

bind dirty_chunk_tracker_top dct_checker u_dct_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_index_valid (rsp_index_valid),
   .rsp_last        (rsp_last),
   .rsp_status      (rsp_status),
   .rsp_dirty_total (rsp_dirty_total)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty chunk tracker testbench
// Drives mark, read, clear and unused commands into the tracker, predicts
// every result from a private copy of the mark store, dirty list, count and
// rebuild flag, and checks each strobed result against the oldest one due.
// ----------------------------------------------------------------------------

import dct_pkg::*;

typedef struct packed {
   logic [IDX_W-1:0]  listed_index;
   logic              index_valid;
   logic              last;
   logic [STAT_W-1:0] status;
   logic [CNT_W-1:0]  dirty_total;
   logic              rebuild_needed;
} tracker_result_type;

// Tracks the expected state of the block and the results still owed by it.
class dirty_list_scoreboard;
   localparam int CHUNK_SLOTS = 4096;
   localparam int LIST_SLOTS  = 64;

   bit [CHUNK_SLOTS-1:0] marks;
   logic [IDX_W-1:0]     listed [LIST_SLOTS];
   int unsigned          list_count;
   bit                   rebuild;
   logic [CFG_W-1:0]     chunk_limit;
   tracker_result_type   owed [$];
   int                   errors;
   int                   requests;
   int                   results;
   int                   overflows;
   int                   filled_reads;

   function new();
      marks        = '0;
      list_count   = 0;
      rebuild      = 1'b1;
      chunk_limit  = CHUNKS_RESET;
      errors       = 0;
      requests     = 0;
      results      = 0;
      overflows    = 0;
      filled_reads = 0;
   endfunction

   function void set_chunk_limit(logic [CFG_W-1:0] value);
      chunk_limit = value;
   endfunction

   function void owe(logic [IDX_W-1:0] idx, logic valid, logic is_last,
                     logic [STAT_W-1:0] status);
      tracker_result_type r;
      r.listed_index   = idx;
      r.index_valid    = valid;
      r.last           = is_last;
      r.status         = status;
      r.dirty_total    = list_count[CNT_W-1:0];
      r.rebuild_needed = rebuild;
      owed.push_back(r);
   endfunction

   function void note_request(logic [1:0] cmd, logic [IDX_W-1:0] idx,
                              logic [LIM_W-1:0] lim);
      int unsigned bound;
      int unsigned cap;
      int unsigned n;
      requests++;
      case (cmd)
         CMD_MARK: begin
            bound = (chunk_limit > CHUNK_SLOTS) ? CHUNK_SLOTS : chunk_limit;
            if (idx >= bound) begin
               owe('0, 1'b0, 1'b1, ST_REJECT);
            end else if (marks[idx]) begin
               owe('0, 1'b0, 1'b1, ST_ALREADY);
            end else begin
               marks[idx] = 1'b1;
               if (list_count < LIST_SLOTS) begin
                  listed[list_count] = idx;
                  list_count++;
                  owe('0, 1'b0, 1'b1, ST_ADDED);
               end else begin
                  rebuild = 1'b1;
                  overflows++;
                  owe('0, 1'b0, 1'b1, ST_FULL);
               end
            end
         end
         CMD_READ: begin
            cap = (lim > LIST_SLOTS) ? LIST_SLOTS : lim;
            n   = (list_count < cap) ? list_count : cap;
            if (n == 0) begin
               owe('0, 1'b0, 1'b1, ST_DONE);
            end else begin
               filled_reads++;
               for (int i = 0; i < n; i++)
                  owe(listed[i], 1'b1, (i == n - 1), ST_DONE);
            end
         end
         CMD_CLEAR: begin
            marks      = '0;
            list_count = 0;
            rebuild    = 1'b0;
            owe('0, 1'b0, 1'b1, ST_DONE);
         end
         default: begin
            owe('0, 1'b0, 1'b1, ST_REJECT);
         end
      endcase
   endfunction

   task report_mismatch(string msg);
      errors++;
      $display("%0t ns: mismatch on result %0d: %s", $time, results, msg);
   endtask

   task check_response(tracker_result_type got);
      tracker_result_type want;
      results++;
      if (owed.size() == 0) begin
         report_mismatch("result arrived with nothing outstanding");
         return;
      end
      want = owed.pop_front();
      if (got.listed_index !== want.listed_index)
         report_mismatch($sformatf("listed_index %0d, expected %0d",
                                   got.listed_index, want.listed_index));
      if (got.index_valid !== want.index_valid)
         report_mismatch($sformatf("index_valid %0b, expected %0b",
                                   got.index_valid, want.index_valid));
      if (got.last !== want.last)
         report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
      if (got.status !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d",
                                   got.status, want.status));
      if (got.dirty_total !== want.dirty_total)
         report_mismatch($sformatf("dirty_total %0d, expected %0d",
                                   got.dirty_total, want.dirty_total));
      if (got.rebuild_needed !== want.rebuild_needed)
         report_mismatch($sformatf("rebuild_needed %0b, expected %0b",
                                   got.rebuild_needed, want.rebuild_needed));
   endtask
endclass

module testbench;
   // The block has no code for the fourth command value; it must be rejected.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_cmd;
   logic [IDX_W-1:0]  req_chunk_index;
   logic [LIM_W-1:0]  req_read_limit;
   logic              rsp_strobe;
   logic [IDX_W-1:0]  rsp_listed_index;
   logic              rsp_index_valid;
   logic              rsp_last;
   logic [STAT_W-1:0] rsp_status;
   logic [CNT_W-1:0]  rsp_dirty_total;
   logic              rsp_rebuild_needed;
   logic              csr_valid;
   logic              csr_ready;
   logic [CFG_W-1:0]  csr_chunks_in_use;

   dirty_list_scoreboard tracker_sb = new;
   int                   settings_used;

   dirty_chunk_tracker_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_chunk_index    (req_chunk_index),
      .req_read_limit     (req_read_limit),
      .rsp_strobe         (rsp_strobe),
      .rsp_listed_index   (rsp_listed_index),
      .rsp_index_valid    (rsp_index_valid),
      .rsp_last           (rsp_last),
      .rsp_status         (rsp_status),
      .rsp_dirty_total    (rsp_dirty_total),
      .rsp_rebuild_needed (rsp_rebuild_needed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_chunks_in_use  (csr_chunks_in_use)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Results cannot be held off, so every strobed cycle is checked at the
   // rising edge that closes it, using the values from before that edge.
   always @(posedge clock) begin
      tracker_result_type seen;
      if (!reset && rsp_strobe) begin
         seen = {rsp_listed_index, rsp_index_valid, rsp_last, rsp_status,
                 rsp_dirty_total, rsp_rebuild_needed};
         tracker_sb.check_response(seen);
      end
   end

   // Mostly back-to-back or short gaps, with an occasional long pause so that
   // idle time lands on every stage of a mark, a read stream and a clear sweep.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Presents one request at the falling edge and holds it until a rising edge
   // finds busy low. When no gap follows, start stays high and the next call
   // simply replaces the fields at the next falling edge, so start is never
   // dropped and raised within one step. Every caller either issues again or
   // lowers start at the very next falling edge.
   task automatic issue_request(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                                input logic [LIM_W-1:0] lim, input int gap);
      @(negedge clock);
      start           = 1'b1;
      req_cmd         = cmd;
      req_chunk_index = idx;
      req_read_limit  = lim;
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      tracker_sb.note_request(cmd, idx, lim);
      if (gap > 0) begin
         @(negedge clock);
         start           = 1'b0;
         req_cmd         = 2'($urandom);
         req_chunk_index = 12'($urandom);
         req_read_limit  = 7'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Lowers start and waits for every owed result, then keeps waiting in case
   // the back end is still finishing its last step.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (tracker_sb.owed.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // The register is only touched once the block has gone quiet.
   task automatic write_chunk_limit(input logic [CFG_W-1:0] value);
      drain();
      @(negedge clock);
      csr_valid         = 1'b1;
      csr_chunks_in_use = value;
      forever begin
         @(posedge clock);
         if (csr_ready)
            break;
      end
      tracker_sb.set_chunk_limit(value);
      settings_used++;
      @(negedge clock);
      csr_valid         = 1'b0;
      csr_chunks_in_use = 13'($urandom);
   endtask

   // Fills the dirty list to its 64 entries and pushes past it, so that the
   // overflow path sets the rebuild flag, then reads back with several limits.
   // Distinct indices come from a stride that is coprime to the chunk count.
   task automatic fill_list_phase();
      int base;
      base = $urandom_range(0, 4095);
      write_chunk_limit(13'd4096);
      issue_request(CMD_CLEAR, 12'($urandom), 7'($urandom), 0);
      for (int i = 0; i < 70; i++)
         issue_request(CMD_MARK, 12'((base + i * 63) % 4096), 7'($urandom), 0);
      issue_request(CMD_READ, 12'($urandom), 7'd127, pick_gap());
      issue_request(CMD_MARK, 12'(base), 7'($urandom), pick_gap());
      issue_request(CMD_READ, 12'($urandom), 7'd64, pick_gap());
      issue_request(CMD_READ, 12'($urandom), 7'd63, pick_gap());
      issue_request(CMD_CLEAR, 12'($urandom), 7'($urandom), pick_gap());
   endtask

   // A mix of commands under one chunk limit. Marks favor a small pool of
   // recent indices so that repeated marks show up, and indices below the
   // limit so that the list actually grows.
   task automatic run_random_phase(input logic [CFG_W-1:0] setting, input int count);
      int         usable;
      int         r;
      int         p;
      logic [IDX_W-1:0] idx;
      logic [LIM_W-1:0] lim;
      logic [IDX_W-1:0] recent [$];
      usable = (setting > 4096) ? 4096 : setting;
      write_chunk_limit(setting);
      for (int i = 0; i < count; i++) begin
         r   = $urandom_range(0, 99);
         idx = 12'($urandom);
         lim = 7'($urandom);
         if (r < 55) begin
            p = $urandom_range(0, 9);
            if (p < 4 && recent.size() > 0)
               idx = recent[$urandom_range(0, recent.size() - 1)];
            else if (p < 8 && usable > 0)
               idx = 12'($urandom_range(0, usable - 1));
            recent.push_back(idx);
            if (recent.size() > 16)
               void'(recent.pop_front());
            issue_request(CMD_MARK, idx, lim, pick_gap());
         end else if (r < 78) begin
            p = $urandom_range(0, 9);
            if (p == 0)
               lim = '0;
            else if (p < 3)
               lim = 7'($urandom_range(65, 127));
            else
               lim = 7'($urandom_range(1, 64));
            issue_request(CMD_READ, idx, lim, pick_gap());
         end else if (r < 86) begin
            issue_request(CMD_CLEAR, idx, lim, pick_gap());
         end else if (r < 91) begin
            issue_request(CMD_UNUSED, idx, lim, pick_gap());
         end else begin
            issue_request(CMD_MARK, idx, lim, pick_gap());
         end
      end
   endtask

   initial begin
      settings_used     = 0;
      reset             = 1'b1;
      start             = 1'b0;
      req_cmd           = CMD_MARK;
      req_chunk_index   = '0;
      req_read_limit    = '0;
      csr_valid         = 1'b0;
      csr_chunks_in_use = CHUNKS_RESET;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset chunk limit. The first read sees the
      // empty list with the rebuild flag still set from reset.
      issue_request(CMD_READ, 12'd0, 7'd64, 0);
      issue_request(CMD_MARK, 12'd0, 7'd0, 0);
      issue_request(CMD_MARK, 12'd4095, 7'd127, 1);
      issue_request(CMD_MARK, 12'd0, 7'd0, 0);
      issue_request(CMD_MARK, 12'd2730, 7'd85, 2);
      issue_request(CMD_MARK, 12'd1365, 7'd42, 0);
      issue_request(CMD_UNUSED, 12'd4095, 7'd127, 0);
      // A zero read limit returns the empty result even with entries in the list.
      issue_request(CMD_READ, 12'd0, 7'd0, 0);
      issue_request(CMD_READ, 12'd0, 7'd1, 3);
      // Limits above the list depth are clamped.
      issue_request(CMD_READ, 12'd4095, 7'd127, 0);
      issue_request(CMD_READ, 12'd0, 7'd64, 0);
      issue_request(CMD_CLEAR, 12'd0, 7'd0, 0);
      // After a clear the list is empty and the rebuild flag is down.
      issue_request(CMD_READ, 12'd0, 7'd3, 1);
      issue_request(CMD_MARK, 12'd4095, 7'd0, 0);
      issue_request(CMD_MARK, 12'd7, 7'd0, 0);
      issue_request(CMD_READ, 12'd0, 7'd2, 0);

      fill_list_phase();

      // Extreme and ordinary chunk limits: one usable chunk, all ones (which
      // saturates to the full store), zero (every mark rejected), and others.
      run_random_phase(13'd1, 30);
      run_random_phase(13'd8191, 30);
      run_random_phase(13'd0, 30);
      run_random_phase(13'd100, 30);
      run_random_phase(13'd4095, 30);
      run_random_phase(13'd64, 30);

      drain();
      repeat (20) @(posedge clock);

      $display("Ran %0d requests yielding %0d results across %0d chunk limits.",
               tracker_sb.requests, tracker_sb.results, settings_used);
      $display("Overflow into rebuild seen %0d times; %0d reads returned entries.",
               tracker_sb.overflows, tracker_sb.filled_reads);
      if (tracker_sb.errors == 0) begin
         $display("[dirty_chunk_tracker_top] OK");
      end else begin
         $display("[dirty_chunk_tracker_top] ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of this stimulus.
   initial begin
      #5_000_000;
      $display("Timed out with %0d results outstanding.", tracker_sb.owed.size());
      $display("[dirty_chunk_tracker_top] ERROR");
      $finish;
   end
endmodule
